@@ rtl/lphm_pkg.sv @@
// lphm_pkg: shared types, constants and the level encoder for the
// peak-hold level meter. No dependencies.

package lphm_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned PeakW  = 16;
    localparam int unsigned LevelW = 4;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned IdxW   = 2;

    localparam logic [CfgW-1:0] OverloadLimitRst = 16'd65535;
    localparam logic [CfgW-1:0] DecayIntervalRst = 16'd50;
    localparam logic [CfgW-1:0] MarkHoldRst      = 16'd1000;
    localparam logic [LevelW-1:0] LevelMax       = 4'd15;

    typedef enum logic [IdxW-1:0] {
        CFG_OVERLOAD_LIMIT = 2'd0,
        CFG_DECAY_INTERVAL = 2'd1,
        CFG_MARK_HOLD      = 2'd2
    } cfg_idx_t;

    // one state update: enable and the item's timestamp
    typedef struct packed {
        logic             en;
        logic [TimeW-1:0] now_ms;
    } step_t;

    // floor(log2(max(v,1)))
    function automatic logic [LevelW-1:0] level_of(input logic [PeakW-1:0] v);
        logic [LevelW-1:0] n;
        n = '0;
        for (int i = 1; i < PeakW; i++) begin
            if (v[i]) begin
                n = LevelW'(i);
            end
        end
        if (n > LevelMax) begin
            n = LevelMax;
        end
        return n;
    endfunction

endpackage

@@ rtl/lphm_chan.sv @@
// lphm_chan: held level and decay deadline of one meter channel.
// Depends on lphm_pkg.

module lphm_chan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lphm_pkg::step_t               step,
    input  logic [lphm_pkg::PeakW-1:0]    peak,
    input  logic [lphm_pkg::CfgW-1:0]     interval_ms,
    output logic [lphm_pkg::LevelW-1:0]   level,
    output logic [lphm_pkg::LevelW-1:0]   level_next,
    output logic                          chg
);

    logic [lphm_pkg::LevelW-1:0] held_reg;
    logic [lphm_pkg::TimeW-1:0]  deadline_reg;
    logic [lphm_pkg::TimeW-1:0]  deadline_next;
    logic [lphm_pkg::LevelW-1:0] lv;
    logic [lphm_pkg::LevelW-1:0] lvl1;
    logic [lphm_pkg::TimeW-1:0]  dl1;
    logic [lphm_pkg::TimeW-1:0]  sum;
    logic                        rise;
    logic                        expire;
    logic                        drop;

    always_comb begin
        lv     = lphm_pkg::level_of(peak);
        sum    = step.now_ms + {{(lphm_pkg::TimeW-lphm_pkg::CfgW){1'b0}}, interval_ms};
        rise   = lv > held_reg;
        lvl1   = rise ? lv : held_reg;
        dl1    = rise ? sum : deadline_reg;
        // deadline may wrap and expire in the same item
        expire = step.now_ms > dl1;
        drop   = expire && (lvl1 != '0);
        level_next    = drop ? lvl1 - 1'b1 : lvl1;
        deadline_next = expire ? sum : dl1;
        chg    = rise || drop;
    end

    assign level = held_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg     <= '0;
            deadline_reg <= '0;
        end else if (step.en) begin
            held_reg     <= level_next;
            deadline_reg <= deadline_next;
        end
    end

endmodule

@@ rtl/lphm_mark.sv @@
// lphm_mark: one sticky status mark with its hold deadline.
// Depends on lphm_pkg.

module lphm_mark (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lphm_pkg::step_t           step,
    input  logic                      trig,
    input  logic [lphm_pkg::CfgW-1:0] hold_ms,
    output logic                      lit_next
);

    logic                       lit_reg;
    logic [lphm_pkg::TimeW-1:0] deadline_reg;
    logic [lphm_pkg::TimeW-1:0] deadline_next;
    logic                       lit1;

    always_comb begin
        lit1          = trig || lit_reg;
        deadline_next = trig ?
            step.now_ms + {{(lphm_pkg::TimeW-lphm_pkg::CfgW){1'b0}}, hold_ms} : deadline_reg;
        lit_next      = lit1 && !(step.now_ms > deadline_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_reg      <= 1'b0;
            deadline_reg <= '0;
        end else if (step.en) begin
            lit_reg      <= lit_next;
            deadline_reg <= deadline_next;
        end
    end

endmodule

@@ rtl/log_peak_hold_meter.sv @@
// log_peak_hold_meter: top level of the two-channel peak-hold level meter.
// Depends on lphm_pkg, lphm_chan and lphm_mark.
//
// Usage:
//   s_ channel: one item per handshake (timestamp, two peaks, compressor flag).
//   m_ channel: one result item per input item, in order (held levels,
//   overload and compressor marks, changed flag).
//   cfg channel: register writes (index 0 overload limit, 1 decay interval,
//   2 mark hold), always ready; write only while the meter is idle.
// Path: an accepted item waits in the input register and moves to the result
//   register once that is empty or its result is being taken.
// Throughput: one item per cycle while m_ready stays high; the state update for an
//   item happens in the cycle it moves from the input register to the result register.
// Reset: levels, marks and deadlines clear, registers take 65535 / 50 / 1000.
// Stall: while m_ready is low the result holds; one more item waits in the
//   input register, after which s_ready drops.

module log_peak_hold_meter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lphm_pkg::TimeW-1:0]    s_now_ms,
    input  logic [lphm_pkg::PeakW-1:0]    s_peak_in,
    input  logic [lphm_pkg::PeakW-1:0]    s_peak_out,
    input  logic                          s_compressor_active,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lphm_pkg::LevelW-1:0]   m_level_in,
    output logic [lphm_pkg::LevelW-1:0]   m_level_out,
    output logic                          m_overload_in_mark,
    output logic                          m_overload_out_mark,
    output logic                          m_compressor_mark,
    output logic                          m_changed,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lphm_pkg::IdxW-1:0]     cfg_index,
    input  logic [lphm_pkg::CfgW-1:0]     cfg_data
);

    logic [lphm_pkg::CfgW-1:0]   overload_limit_reg;
    logic [lphm_pkg::CfgW-1:0]   decay_interval_reg;
    logic [lphm_pkg::CfgW-1:0]   mark_hold_reg;

    logic                        in_valid_reg;
    logic [lphm_pkg::TimeW-1:0]  now_reg;
    logic [lphm_pkg::PeakW-1:0]  peak_in_reg;
    logic [lphm_pkg::PeakW-1:0]  peak_out_reg;
    logic                        comp_reg;

    logic                        out_valid_reg;
    logic [lphm_pkg::LevelW-1:0] level_in_reg;
    logic [lphm_pkg::LevelW-1:0] level_out_reg;
    logic                        ovl_in_reg;
    logic                        ovl_out_reg;
    logic                        comp_mark_reg;
    logic                        changed_reg;

    logic                        advance;
    lphm_pkg::step_t             step;
    logic                        ovl_in_trig;
    logic                        ovl_out_trig;
    logic [lphm_pkg::LevelW-1:0] lvl_in;
    logic [lphm_pkg::LevelW-1:0] lvl_out;
    logic [lphm_pkg::LevelW-1:0] lvl_in_next;
    logic [lphm_pkg::LevelW-1:0] lvl_out_next;
    logic                        chg_in;
    logic                        chg_out;
    logic                        ovl_in_next;
    logic                        ovl_out_next;
    logic                        comp_next;
    logic                        changed_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overload_limit_reg <= lphm_pkg::OverloadLimitRst;
            decay_interval_reg <= lphm_pkg::DecayIntervalRst;
            mark_hold_reg      <= lphm_pkg::MarkHoldRst;
        end else if (cfg_valid) begin
            case (lphm_pkg::cfg_idx_t'(cfg_index))
                lphm_pkg::CFG_OVERLOAD_LIMIT: begin
                    overload_limit_reg <= cfg_data;
                end
                lphm_pkg::CFG_DECAY_INTERVAL: begin
                    decay_interval_reg <= cfg_data;
                end
                lphm_pkg::CFG_MARK_HOLD: begin
                    mark_hold_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg      <= s_now_ms;
            peak_in_reg  <= s_peak_in;
            peak_out_reg <= s_peak_out;
            comp_reg     <= s_compressor_active;
        end
    end

    always_comb begin
        step.en      = advance;
        step.now_ms  = now_reg;
        ovl_in_trig  = peak_in_reg > overload_limit_reg;
        ovl_out_trig = peak_out_reg > overload_limit_reg;
        changed_next = chg_in || chg_out || ovl_in_trig || ovl_out_trig || comp_reg;
    end

    lphm_chan u_chan_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .peak        (peak_in_reg),
        .interval_ms (decay_interval_reg),
        .level       (lvl_in),
        .level_next  (lvl_in_next),
        .chg         (chg_in)
    );

    lphm_chan u_chan_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .peak        (peak_out_reg),
        .interval_ms (decay_interval_reg),
        .level       (lvl_out),
        .level_next  (lvl_out_next),
        .chg         (chg_out)
    );

    lphm_mark u_mark_ovl_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .trig     (ovl_in_trig),
        .hold_ms  (mark_hold_reg),
        .lit_next (ovl_in_next)
    );

    lphm_mark u_mark_ovl_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .trig     (ovl_out_trig),
        .hold_ms  (mark_hold_reg),
        .lit_next (ovl_out_next)
    );

    lphm_mark u_mark_comp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .trig     (comp_reg),
        .hold_ms  (mark_hold_reg),
        .lit_next (comp_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            level_in_reg  <= lvl_in_next;
            level_out_reg <= lvl_out_next;
            ovl_in_reg    <= ovl_in_next;
            ovl_out_reg   <= ovl_out_next;
            comp_mark_reg <= comp_next;
            changed_reg   <= changed_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_level_in          = level_in_reg;
    assign m_level_out         = level_out_reg;
    assign m_overload_in_mark  = ovl_in_reg;
    assign m_overload_out_mark = ovl_out_reg;
    assign m_compressor_mark   = comp_mark_reg;
    assign m_changed           = changed_reg;

`ifndef SYNTH
    // an update without a change flag leaves both held levels alone
    a_quiet_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !changed_next |=> lvl_in == $past(lvl_in) && lvl_out == $past(lvl_out))
        else $error("held level moved without changed flag");

    // a stalled result with a waiting item blocks new input
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready && in_valid_reg |-> !s_ready)
        else $error("input accepted while both stages full");

    // the reported levels match the channel state after the update
    a_result_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_level_in == lvl_in && m_level_out == lvl_out)
        else $error("result levels differ from held state");
`endif

endmodule
